// ===== src/ils_pkg.sv =====
// shared types and constants for the indexed list store
package ils_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned PosW    = 8;
  localparam int unsigned ValW    = 32;
  localparam int unsigned CountW  = 9;
  localparam int unsigned StatusW = 2;

  localparam int unsigned SDataW = 40;  // position + item_value
  localparam int unsigned MDataW = 48;  // read_value + element_count, padded to bytes

  typedef enum logic [KindW-1:0] {
    KIND_APPEND = 2'd0,
    KIND_READ   = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_RSVD  = 2'd3
  } status_e;

endpackage

// ===== src/ils_ram.sv =====
// single write port, single read port element memory with registered read data
module ils_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/indexed_list_store.sv =====
// top level of the indexed list store: sequencer, count and output register
//
// channel  direction  tdata                                   tuser
// s_axis   in         [7:0] position, [39:8] item_value       [1:0] kind
// m_axis   out        [31:0] read_value, [40:32] element_count [1:0] status
//
// remove of index p from a list of n moves each later element down one place: the memory
// read port moves one element down per cycle ahead of the write port.
// reset clears the count and handshakes; memory contents are not cleared.
// s_axis_tready is low while an item is in work; a result waits in the output
// register and the next item is accepted behind it.
module indexed_list_store #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [ils_pkg::SDataW-1:0]  s_axis_tdata,   // position, item_value
  input  logic [ils_pkg::KindW-1:0]   s_axis_tuser,   // kind
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [ils_pkg::MDataW-1:0]  m_axis_tdata,   // read_value, element_count, zero pad
  output logic [ils_pkg::StatusW-1:0] m_axis_tuser    // status
);

  import ils_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NW = CW + 1;
  localparam int unsigned PW = (CW > PosW) ? CW : PosW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SHIFT,
    ST_OUT
  } state_e;

  state_e                state_q;
  logic [CW-1:0]         count_q;
  logic [AW-1:0]         idx_q;
  logic                  is_rm_q;
  logic [DATA_WIDTH-1:0] res_data_q;
  status_e               res_status_q;
  logic                  m_valid_q;
  logic [MDataW-1:0]     m_data_q;
  status_e               m_status_q;

  logic [PosW-1:0]       in_pos;
  logic [ValW-1:0]       in_val;
  kind_e                 in_kind;
  logic                  accept;
  logic                  full;
  logic                  pos_bad;
  logic                  out_free;
  logic                  fetch_last;
  logic                  shift_last;

  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr;
  logic [DATA_WIDTH-1:0] ram_wr_data;
  logic                  ram_rd_en;
  logic [AW-1:0]         ram_rd_addr;
  logic [DATA_WIDTH-1:0] ram_rd_data;

  assign in_pos  = s_axis_tdata[PosW-1:0];
  assign in_val  = s_axis_tdata[PosW +: ValW];
  assign in_kind = kind_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CW'(CAPACITY));
  assign pos_bad       = (PW'(in_pos) >= PW'(count_q));
  assign out_free      = !m_valid_q || m_axis_tready;

  // no later element to move down
  assign fetch_last = (NW'(idx_q) + NW'(1) >= NW'(count_q));
  assign shift_last = (NW'(idx_q) + NW'(2) >= NW'(count_q));

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = count_q[AW-1:0];
    ram_wr_data = DATA_WIDTH'(in_val);
    ram_rd_en   = 1'b0;
    ram_rd_addr = AW'(in_pos);
    case (state_q)
      ST_IDLE: begin
        if (accept && in_kind == KIND_APPEND && !full) begin
          ram_wr_en = 1'b1;
        end
        if (accept && (in_kind == KIND_READ || in_kind == KIND_REMOVE) && !pos_bad) begin
          ram_rd_en = 1'b1;
        end
      end
      ST_FETCH: begin
        ram_rd_en   = is_rm_q && !fetch_last;
        ram_rd_addr = idx_q + AW'(1);
      end
      ST_SHIFT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_q;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = !shift_last;
        ram_rd_addr = idx_q + AW'(2);
      end
      default: begin
      end
    endcase
  end

  ils_ram #(
    .Depth (CAPACITY),
    .Width (DATA_WIDTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      is_rm_q      <= 1'b0;
      res_data_q   <= '0;
      res_status_q <= STATUS_OK;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
      m_status_q   <= STATUS_OK;
    end else begin
      // in ST_OUT the output register either reloads or holds its word
      if (m_valid_q && m_axis_tready && state_q != ST_OUT) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            res_data_q   <= '0;
            res_status_q <= STATUS_OK;
            idx_q        <= AW'(in_pos);
            is_rm_q      <= (in_kind == KIND_REMOVE);
            state_q      <= ST_OUT;
            case (in_kind)
              KIND_APPEND: begin
                if (full) begin
                  res_status_q <= STATUS_FULL;
                end else begin
                  count_q <= count_q + CW'(1);
                end
              end
              KIND_READ, KIND_REMOVE: begin
                if (pos_bad) begin
                  res_status_q <= STATUS_RANGE;
                end else begin
                  state_q <= ST_FETCH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FETCH: begin
          res_data_q <= ram_rd_data;
          if (!is_rm_q) begin
            state_q <= ST_OUT;
          end else if (fetch_last) begin
            count_q <= count_q - CW'(1);
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          idx_q <= idx_q + AW'(1);
          if (shift_last) begin
            count_q <= count_q - CW'(1);
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_valid_q  <= 1'b1;
            m_data_q   <= {7'd0, CountW'(count_q), ValW'(res_data_q)};
            m_status_q <= res_status_q;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

endmodule

// ===== tb/tb_indexed_list_store.sv =====
// self-checking testbench for indexed_list_store: directed table, then random op sequences
`timescale 1ns / 1ps

module tb_indexed_list_store;
  import ils_pkg::*;

  localparam int unsigned ListCap    = 256;
  localparam int unsigned TotalWords = 1700;
  localparam int unsigned NumRows    = 21;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pos;
    logic [31:0] val;
  } list_op_t;

  typedef struct packed {
    logic [31:0] value;
    logic [8:0]  count;
    status_e     status;
  } list_result_t;

  // typed = 1 means the expected result is written out in the row
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pos;
    logic [31:0] val;
    logic        typed;
    logic [31:0] rvalue;
    logic [8:0]  rcount;
    status_e     rstatus;
  } list_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [SDataW-1:0]    s_axis_tdata;   // position, item_value
  logic [KindW-1:0]     s_axis_tuser;   // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [MDataW-1:0]    m_axis_tdata;   // read_value, element_count, zero pad
  logic [StatusW-1:0]   m_axis_tuser;   // status

  // shadow copy of the list
  logic [31:0]          shadow_list [ListCap];
  logic [8:0]           shadow_len;

  list_result_t         pending_results [$];
  int unsigned          mismatch_count;
  int unsigned          words_sent;
  int unsigned          src_idle_pct;
  int unsigned          sink_idle_pct;
  int unsigned          sink_hold_cycles;

  list_row_t directed_rows [NumRows] = '{
    '{KIND_READ,   8'd0,   32'h0000_0000, 1'b1, 32'h0,         9'd0, STATUS_RANGE},
    '{KIND_REMOVE, 8'd0,   32'h0000_0000, 1'b1, 32'h0,         9'd0, STATUS_RANGE},
    '{KIND_NONE,   8'd255, 32'hFFFF_FFFF, 1'b1, 32'h0,         9'd0, STATUS_OK},
    '{KIND_APPEND, 8'd255, 32'hFFFF_FFFF, 1'b1, 32'h0,         9'd1, STATUS_OK},
    '{KIND_APPEND, 8'd0,   32'h0000_0000, 1'b1, 32'h0,         9'd2, STATUS_OK},
    '{KIND_APPEND, 8'd128, 32'h8000_0001, 1'b1, 32'h0,         9'd3, STATUS_OK},
    '{KIND_READ,   8'd0,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 9'd3, STATUS_OK},
    '{KIND_READ,   8'd2,   32'hFFFF_FFFF, 1'b1, 32'h8000_0001, 9'd3, STATUS_OK},
    '{KIND_READ,   8'd3,   32'h0000_0000, 1'b1, 32'h0,         9'd3, STATUS_RANGE},
    '{KIND_READ,   8'd255, 32'h0000_0000, 1'b1, 32'h0,         9'd3, STATUS_RANGE},
    '{KIND_REMOVE, 8'd255, 32'h0000_0000, 1'b1, 32'h0,         9'd3, STATUS_RANGE},
    '{KIND_APPEND, 8'd0,   32'h1234_5678, 1'b1, 32'h0,         9'd4, STATUS_OK},
    '{KIND_REMOVE, 8'd1,   32'h0000_0000, 1'b1, 32'h0,         9'd3, STATUS_OK},
    '{KIND_READ,   8'd1,   32'h0000_0000, 1'b0, 32'h0,         9'd0, STATUS_OK},
    '{KIND_REMOVE, 8'd2,   32'h0000_0000, 1'b0, 32'h0,         9'd0, STATUS_OK},
    '{KIND_REMOVE, 8'd0,   32'h0000_0000, 1'b0, 32'h0,         9'd0, STATUS_OK},
    '{KIND_READ,   8'd0,   32'h0000_0000, 1'b0, 32'h0,         9'd0, STATUS_OK},
    '{KIND_REMOVE, 8'd0,   32'h0000_0000, 1'b0, 32'h0,         9'd0, STATUS_OK},
    '{KIND_REMOVE, 8'd0,   32'h0000_0000, 1'b1, 32'h0,         9'd0, STATUS_RANGE},
    '{KIND_APPEND, 8'd0,   32'h5A5A_5A5A, 1'b0, 32'h0,         9'd0, STATUS_OK},
    '{KIND_NONE,   8'd0,   32'h0000_0000, 1'b0, 32'h0,         9'd0, STATUS_OK}
  };

  indexed_list_store #(
    .CAPACITY  (ListCap),
    .DATA_WIDTH(32)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 200) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // applies one op to the shadow list and returns what the block must answer
  function automatic list_result_t list_apply(input list_op_t op);
    list_result_t r;
    r = '{value: '0, count: '0, status: STATUS_OK};
    case (op.kind)
      KIND_APPEND: begin
        if (shadow_len >= ListCap) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_list[shadow_len] = op.val;
          shadow_len++;
        end
      end
      KIND_READ, KIND_REMOVE: begin
        if (op.pos >= shadow_len) begin
          r.status = STATUS_RANGE;
        end else begin
          r.value = shadow_list[op.pos];
          if (op.kind == KIND_REMOVE) begin
            for (int i = op.pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
            shadow_len--;
          end
        end
      end
      default: ;
    endcase
    r.count = shadow_len;
    return r;
  endfunction

  // ends at the rising edge where the word was taken
  task automatic send_op(input list_op_t op, input bit typed = 1'b0,
                         input list_result_t typed_res = '0);
    list_result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op.kind;
    s_axis_tdata  <= {op.val, op.pos};
    do @(posedge clk_i); while (!s_axis_tready);
    res = list_apply(op);
    pending_results.push_back(typed ? typed_res : res);
    words_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // endpoints favored, since shifting differs most there
  function automatic logic [7:0] in_range_pos();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'(shadow_len - 1);
      default: return 8'($urandom_range(shadow_len - 1, 0));
    endcase
  endfunction

  function automatic list_op_t pick_mixed_op();
    list_op_t    op;
    int unsigned r;
    r       = $urandom_range(99);
    op.val  = $urandom();
    op.pos  = 8'($urandom_range(255));
    op.kind = KIND_APPEND;
    if (r >= 40 && r < 90) begin
      op.kind = (r < 65) ? KIND_READ : KIND_REMOVE;
      if (shadow_len != 0) op.pos = in_range_pos();
    end else if (r >= 90 && r < 96) begin
      op.kind = r[0] ? KIND_READ : KIND_REMOVE;
      if (shadow_len < ListCap) op.pos = 8'($urandom_range(255, shadow_len));
    end else if (r >= 96) begin
      op.kind = KIND_NONE;
    end
    return op;
  endfunction

  // append until full, then a few appends that must be refused
  task automatic run_fill();
    list_op_t op;
    while (shadow_len < ListCap) begin
      op = '{KIND_APPEND, 8'($urandom_range(255)), $urandom()};
      send_op(op);
    end
    repeat ($urandom_range(3, 1)) begin
      op = '{KIND_APPEND, 8'($urandom_range(255)), $urandom()};
      send_op(op);
    end
  endtask

  task automatic run_drain();
    list_op_t op;
    while (shadow_len != 0) begin
      op = '{KIND_REMOVE, in_range_pos(), $urandom()};
      send_op(op);
    end
    repeat ($urandom_range(2, 1)) begin
      op = '{$urandom_range(1) ? KIND_READ : KIND_REMOVE, 8'($urandom_range(255)), $urandom()};
      send_op(op);
    end
  endtask

  // receiver: random tready, or a counted hold-off when asked for
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        sink_hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    list_result_t want;
    logic [31:0]  got_value;
    logic [8:0]   got_count;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_value = m_axis_tdata[ValW-1:0];
      got_count = m_axis_tdata[ValW +: CountW];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word: value %h count %0d status %0d",
                                  got_value, got_count, m_axis_tuser));
      end else begin
        want = pending_results.pop_front();
        if (got_value !== want.value)
          report_mismatch($sformatf("read_value %h, expected %h", got_value, want.value));
        if (got_count !== want.count)
          report_mismatch($sformatf("element_count %0d, expected %0d", got_count, want.count));
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", m_axis_tuser, want.status));
      end
    end
  end

  initial begin
    #30_000_000;
    $display("tb_indexed_list_store: done, errors");
    $finish;
  end

  initial begin
    list_op_t     op;
    list_result_t typed_res;
    int unsigned  guard;
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = '0;
    shadow_len       = '0;
    mismatch_count   = 0;
    words_sent       = 0;
    src_idle_pct     = 30;
    sink_idle_pct    = 30;
    sink_hold_cycles = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      op        = '{directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].val};
      typed_res = '{directed_rows[i].rvalue, directed_rows[i].rcount, directed_rows[i].rstatus};
      send_op(op, directed_rows[i].typed, typed_res);
    end

    // reach the full list early
    run_fill();

    // output held off while the sender keeps offering, so the input stalls
    wait_results_drained();
    sink_hold_cycles = 400;
    src_idle_pct     = 0;
    repeat (12) send_op(pick_mixed_op());
    src_idle_pct     = 30;
    wait_results_drained();

    while (words_sent < TotalWords) begin
      if (words_sent > 700 && words_sent < 950) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = 30;
        sink_idle_pct = 30;
      end
      if ($urandom_range(7) == 0) wait_results_drained();
      case ($urandom_range(9))
        0, 1: run_fill();
        2, 3: run_drain();
        9: begin
          repeat ($urandom_range(15, 5)) begin
            op = '{kind_e'($urandom_range(3)), 8'($urandom_range(255)), $urandom()};
            send_op(op);
          end
        end
        default: repeat ($urandom_range(40, 10)) send_op(pick_mixed_op());
      endcase
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200_000) begin
      @(negedge clk_i);
      guard++;
    end
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", pending_results.size()));
    // room for a stray word after a long shift
    repeat (300) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb_indexed_list_store: done, clean");
    end else begin
      $display("tb_indexed_list_store: done, errors");
    end
    $finish;
  end

endmodule
